### rtl/ctti_pkg.sv
// Package for the cyclic time-table interpolator: request and result types,
// control and status structs between the controller and the datapath, and shared constants.
// Depends on nothing.
package ctti_pkg;

    localparam int MAX_STEPS = 64;
    localparam int MAX_ROWS  = 16;
    localparam int STEP_W    = 6;
    localparam int ROW_W     = 4;
    localparam int TIME_W    = 48;
    localparam int VAL_W     = 32;
    localparam int DT_W      = 47;
    localparam int TW        = 51;   // working time width, holds wrapped times and periods
    localparam int DIV_W     = 50;   // divisor and remainder width
    localparam int DVD_W     = 49;   // dividend/quotient shift register width
    localparam int CNT_W     = 6;

    localparam logic [CNT_W-1:0] MUL_STEPS       = 6'd32;
    localparam logic [CNT_W-1:0] DIV_STEPS_WIDE  = 6'd49;
    localparam logic [CNT_W-1:0] DIV_STEPS_INTERP = 6'd33;

    localparam logic [1:0] FUNC_TIME  = 2'd0;
    localparam logic [1:0] FUNC_VALUE = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_NOINT = 2'd1;
    localparam logic [1:0] STAT_ROW   = 2'd2;

    localparam logic [2:0] REG_STEPS    = 3'd0;
    localparam logic [2:0] REG_ROWS     = 3'd1;
    localparam logic [2:0] REG_INTERP   = 3'd2;
    localparam logic [2:0] REG_CYCLE    = 3'd3;
    localparam logic [2:0] REG_ADAPTIVE = 3'd4;
    localparam logic [2:0] REG_DT       = 3'd5;

    localparam logic [4:0] OP_NONE       = 5'd0;
    localparam logic [4:0] OP_LATCH      = 5'd1;
    localparam logic [4:0] OP_ROWBAD     = 5'd2;
    localparam logic [4:0] OP_CAP_T0     = 5'd3;
    localparam logic [4:0] OP_CAP_TLAST  = 5'd4;
    localparam logic [4:0] OP_CDIV       = 5'd5;
    localparam logic [4:0] OP_CFIX       = 5'd6;
    localparam logic [4:0] OP_PER        = 5'd7;
    localparam logic [4:0] OP_MDIV       = 5'd8;
    localparam logic [4:0] OP_WRAP       = 5'd9;
    localparam logic [4:0] OP_SR_PREV    = 5'd10;
    localparam logic [4:0] OP_SR_BRKT    = 5'd11;
    localparam logic [4:0] OP_CAP_V0     = 5'd12;
    localparam logic [4:0] OP_MUL_START  = 5'd13;
    localparam logic [4:0] OP_MUL_STEP   = 5'd14;
    localparam logic [4:0] OP_IDIV       = 5'd15;
    localparam logic [4:0] OP_RES_VAL    = 5'd16;
    localparam logic [4:0] OP_RES_NOINT  = 5'd17;
    localparam logic [4:0] OP_RES_INTERP = 5'd18;

    typedef struct packed {
        logic [1:0]               func;
        logic [STEP_W-1:0]        step_index;
        logic [ROW_W-1:0]         row_index;
        logic signed [TIME_W-1:0] time_in;
        logic signed [VAL_W-1:0]  value_in;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [1:0]              status;
    } res_t;

    typedef struct packed {
        logic [4:0]        op;
        logic [STEP_W-1:0] taddr;
        logic [STEP_W-1:0] vstep;
    } cmd_t;

    typedef struct packed {
        logic              is_query;
        logic              row_bad;
        logic              interp_en;
        logic              cycle_en;
        logic              adaptive;
        logic [STEP_W-1:0] n_last;
        logic              div_busy;
        logic              p_pos;
        logic              t_lt_t0;
        logic              t_gt_tlast;
        logic              eq_prev;
        logic              brkt;
    } sts_t;

endpackage

### rtl/ctti_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions of a query.
// Depends on ctti_pkg.
module ctti_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [ctti_pkg::CNT_W-1:0]    steps,
    input  logic [ctti_pkg::DIV_W-1:0]    r_init,
    input  logic [ctti_pkg::DVD_W-1:0]    d_init,
    input  logic [ctti_pkg::DIV_W-1:0]    divisor,
    output logic                          busy,
    output logic [ctti_pkg::DVD_W-1:0]    quo,
    output logic [ctti_pkg::DIV_W-1:0]    rem
);

    logic [ctti_pkg::DIV_W-1:0] r_reg, r_next;
    logic [ctti_pkg::DVD_W-1:0] q_reg, q_next;
    logic [ctti_pkg::DIV_W-1:0] div_reg;
    logic [ctti_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [ctti_pkg::DIV_W:0]   trial;
    logic [ctti_pkg::DIV_W:0]   diff;
    logic                       ge;

    always_comb
    begin
        trial = {r_reg, q_reg[ctti_pkg::DVD_W-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});
        r_next = ge ? diff[ctti_pkg::DIV_W-1:0] : trial[ctti_pkg::DIV_W-1:0];
        q_next = {q_reg[ctti_pkg::DVD_W-2:0], ge};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (load)
        begin
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            r_reg   <= r_init;
            q_reg   <= d_init;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;
    assign rem  = r_reg;

endmodule

### rtl/ctti_dp.sv
// Datapath of the interpolator: configuration registers, time and value memories,
// period wrapping, search comparators, shift-add multiplier and the shared divider.
// Depends on ctti_pkg and ctti_div.
module ctti_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  ctti_pkg::req_t             request,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [ctti_pkg::DT_W-1:0]  cfg_data,
    input  ctti_pkg::cmd_t             cmd,
    output ctti_pkg::sts_t             sts,
    output ctti_pkg::res_t             result
);

    localparam int TIME_W = ctti_pkg::TIME_W;
    localparam int TW     = ctti_pkg::TW;

    // Configuration.
    logic [ctti_pkg::STEP_W-1:0] n_last_reg;
    logic [ctti_pkg::ROW_W:0]    rows_reg;
    logic                        interp_reg, cycle_reg, adaptive_reg;
    logic [ctti_pkg::DT_W-1:0]   dt_reg;
    logic [6:0]                  steps_raw;
    logic [4:0]                  rows_raw;

    // Storage.
    logic signed [TIME_W-1:0] t_mem [ctti_pkg::MAX_STEPS];
    logic signed [ctti_pkg::VAL_W-1:0] v_mem [ctti_pkg::MAX_STEPS*ctti_pkg::MAX_ROWS];
    logic signed [TIME_W-1:0] tdata;
    logic signed [ctti_pkg::VAL_W-1:0] vdata;

    // Query working registers.
    logic [ctti_pkg::ROW_W-1:0] row_reg;
    logic signed [TW-1:0]       t_reg, tend_reg, p_reg;
    logic signed [TIME_W-1:0]   t0_reg, tlast_reg, prev_reg;
    logic                       t_ge_reg, neg_reg;
    logic [TIME_W-1:0]          off_reg, den_reg;
    logic signed [ctti_pkg::VAL_W-1:0] v0_reg;
    logic [TIME_W-1:0]          hi_reg;
    logic [ctti_pkg::VAL_W-1:0] lo_reg;
    ctti_pkg::res_t             res_reg;

    // Combinational terms.
    logic signed [TW-1:0]     t0x, tlastx, prevx, tdatax;
    logic [TIME_W-1:0]        tabs;
    logic [ctti_pkg::DT_W-1:0] dt_eff;
    logic signed [TW-1:0]     dtx, remx;
    logic signed [TW-1:0]     tend_calc, tdiff, tdiff_abs;
    logic                     t_ge;
    logic signed [ctti_pkg::VAL_W:0] dv;
    logic [ctti_pkg::VAL_W-1:0] mag;
    logic [TIME_W:0]          msum;
    logic [81:0]              num;
    logic [ctti_pkg::VAL_W-1:0] q;

    // Divider port.
    logic                        div_load, div_busy;
    logic [ctti_pkg::CNT_W-1:0]  div_steps;
    logic [ctti_pkg::DIV_W-1:0]  div_rinit, div_divisor, div_rem;
    logic [ctti_pkg::DVD_W-1:0]  div_dinit, div_quo;

    assign steps_raw = cfg_data[6:0];
    assign rows_raw  = cfg_data[4:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_last_reg   <= '0;
            rows_reg     <= 5'd1;
            interp_reg   <= 1'b1;
            cycle_reg    <= 1'b0;
            adaptive_reg <= 1'b0;
            dt_reg       <= 47'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ctti_pkg::REG_STEPS:
                begin
                    if (steps_raw == 7'd0)
                        n_last_reg <= '0;
                    else if (steps_raw > 7'(ctti_pkg::MAX_STEPS))
                        n_last_reg <= 6'(ctti_pkg::MAX_STEPS - 1);
                    else
                        n_last_reg <= 6'(steps_raw - 7'd1);
                end
                ctti_pkg::REG_ROWS:
                begin
                    if (rows_raw == 5'd0)
                        rows_reg <= 5'd1;
                    else if (rows_raw > 5'(ctti_pkg::MAX_ROWS))
                        rows_reg <= 5'(ctti_pkg::MAX_ROWS);
                    else
                        rows_reg <= rows_raw;
                end
                ctti_pkg::REG_INTERP:   interp_reg   <= cfg_data[0];
                ctti_pkg::REG_CYCLE:    cycle_reg    <= cfg_data[0];
                ctti_pkg::REG_ADAPTIVE: adaptive_reg <= cfg_data[0];
                ctti_pkg::REG_DT:       dt_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Loads are written straight from the request; reads are registered.
    always_ff @(posedge clk)
    begin
        if (accept && request.func == ctti_pkg::FUNC_TIME)
            t_mem[request.step_index] <= request.time_in;
        tdata <= t_mem[cmd.taddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && request.func == ctti_pkg::FUNC_VALUE)
            v_mem[{request.row_index, request.step_index}] <= request.value_in;
        vdata <= v_mem[{row_reg, cmd.vstep}];
    end

    always_comb
    begin
        t0x    = TW'(t0_reg);
        tlastx = TW'(tlast_reg);
        prevx  = TW'(prev_reg);
        tdatax = TW'(tdata);
        tabs   = tlast_reg[TIME_W-1] ? TIME_W'(-tlast_reg) : TIME_W'(tlast_reg);
        dt_eff = (dt_reg == '0) ? 47'd1 : dt_reg;
        dtx    = TW'({1'b0, dt_eff});
        remx   = TW'({1'b0, div_rem});
        // Ceiling to a multiple of dt from |t_last| % dt; t_last as is if adaptive.
        if (adaptive_reg)
            tend_calc = tlastx;
        else if (!tlast_reg[TIME_W-1])
            tend_calc = (div_rem == '0) ? tlastx : tlastx + dtx - remx;
        else
            tend_calc = tlastx + remx;
        tdiff     = t_reg - t0x;
        t_ge      = (t_reg >= t0x);
        tdiff_abs = t_ge ? tdiff : -tdiff;
        dv   = (ctti_pkg::VAL_W+1)'(vdata) - (ctti_pkg::VAL_W+1)'(v0_reg);
        mag  = dv[ctti_pkg::VAL_W] ? ctti_pkg::VAL_W'(-dv) : dv[ctti_pkg::VAL_W-1:0];
        msum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, off_reg} : '0);
        num  = {1'b0, hi_reg, lo_reg, 1'b0} + 82'(den_reg);
        q    = div_quo[ctti_pkg::VAL_W-1:0];

        div_load    = 1'b0;
        div_steps   = ctti_pkg::DIV_STEPS_WIDE;
        div_rinit   = '0;
        div_dinit   = {1'b0, tabs};
        div_divisor = ctti_pkg::DIV_W'(dt_eff);
        case (cmd.op)
            ctti_pkg::OP_CDIV:
                div_load = 1'b1;
            ctti_pkg::OP_MDIV:
            begin
                div_load    = 1'b1;
                div_dinit   = tdiff_abs[ctti_pkg::DVD_W-1:0];
                div_divisor = p_reg[ctti_pkg::DIV_W-1:0];
            end
            ctti_pkg::OP_IDIV:
            begin
                // Rounded quotient (2*|dv|*off + den) / (2*den), known to fit 33 bits.
                div_load    = 1'b1;
                div_steps   = ctti_pkg::DIV_STEPS_INTERP;
                div_rinit   = ctti_pkg::DIV_W'(num[81:33]);
                div_dinit   = {num[32:0], 16'd0};
                div_divisor = ctti_pkg::DIV_W'({den_reg, 1'b0});
            end
            default: ;
        endcase
    end

    ctti_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (div_load),
        .steps   (div_steps),
        .r_init  (div_rinit),
        .d_init  (div_dinit),
        .divisor (div_divisor),
        .busy    (div_busy),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ctti_pkg::OP_LATCH:
            begin
                row_reg <= request.row_index;
                t_reg   <= TW'(request.time_in);
            end
            ctti_pkg::OP_ROWBAD:
            begin
                res_reg.result_value <= '0;
                res_reg.status       <= ctti_pkg::STAT_ROW;
            end
            ctti_pkg::OP_CAP_T0:    t0_reg    <= tdata;
            ctti_pkg::OP_CAP_TLAST: tlast_reg <= tdata;
            ctti_pkg::OP_CFIX:      tend_reg  <= tend_calc;
            ctti_pkg::OP_PER:       p_reg     <= tend_reg - t0x;
            ctti_pkg::OP_MDIV:      t_ge_reg  <= t_ge;
            ctti_pkg::OP_WRAP:
            begin
                if (t_ge_reg)
                    t_reg <= (div_rem == '0) ? tend_reg : t0x + remx;
                else
                    t_reg <= tend_reg - remx;
            end
            ctti_pkg::OP_SR_PREV:   prev_reg <= tdata;
            ctti_pkg::OP_SR_BRKT:
            begin
                off_reg <= TIME_W'(t_reg - prevx);
                den_reg <= TIME_W'(tdatax - prevx);
            end
            ctti_pkg::OP_CAP_V0:    v0_reg <= vdata;
            ctti_pkg::OP_MUL_START:
            begin
                neg_reg <= dv[ctti_pkg::VAL_W];
                hi_reg  <= '0;
                lo_reg  <= mag;
            end
            ctti_pkg::OP_MUL_STEP:
            begin
                hi_reg <= msum[TIME_W:1];
                lo_reg <= {msum[0], lo_reg[ctti_pkg::VAL_W-1:1]};
            end
            ctti_pkg::OP_RES_VAL:
            begin
                res_reg.result_value <= vdata;
                res_reg.status       <= ctti_pkg::STAT_OK;
            end
            ctti_pkg::OP_RES_NOINT:
            begin
                res_reg.result_value <= '0;
                res_reg.status       <= ctti_pkg::STAT_NOINT;
            end
            ctti_pkg::OP_RES_INTERP:
            begin
                res_reg.result_value <= neg_reg ? v0_reg - q : v0_reg + q;
                res_reg.status       <= ctti_pkg::STAT_OK;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        sts.is_query   = (request.func == ctti_pkg::FUNC_QUERY);
        sts.row_bad    = ({1'b0, request.row_index} >= rows_reg);
        sts.interp_en  = interp_reg;
        sts.cycle_en   = cycle_reg;
        sts.adaptive   = adaptive_reg;
        sts.n_last     = n_last_reg;
        sts.div_busy   = div_busy;
        sts.p_pos      = !p_reg[TW-1] && (p_reg != '0);
        sts.t_lt_t0    = (t_reg < t0x);
        sts.t_gt_tlast = (t_reg > tlastx);
        sts.eq_prev    = (t_reg == prevx);
        sts.brkt       = (prevx < t_reg) && (t_reg < tdatax);
    end

    assign result = res_reg;

endmodule

### rtl/ctti_ctrl.sv
// Controller of the interpolator: sequences table reads, period wrapping, the
// linear search, multiplication and division for one query at a time.
// Depends on ctti_pkg.
module ctti_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ctti_pkg::sts_t sts,
    output ctti_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RD1    = 5'd1;
    localparam logic [4:0] S_RD2    = 5'd2;
    localparam logic [4:0] S_CSTART = 5'd3;
    localparam logic [4:0] S_CWAIT  = 5'd4;
    localparam logic [4:0] S_CFIX   = 5'd5;
    localparam logic [4:0] S_PER    = 5'd6;
    localparam logic [4:0] S_PCHK   = 5'd7;
    localparam logic [4:0] S_MWAIT  = 5'd8;
    localparam logic [4:0] S_WRAP   = 5'd9;
    localparam logic [4:0] S_CMP    = 5'd10;
    localparam logic [4:0] S_SR1    = 5'd11;
    localparam logic [4:0] S_SR2    = 5'd12;
    localparam logic [4:0] S_SRL    = 5'd13;
    localparam logic [4:0] S_V0     = 5'd14;
    localparam logic [4:0] S_V1     = 5'd15;
    localparam logic [4:0] S_V2     = 5'd16;
    localparam logic [4:0] S_MUL    = 5'd17;
    localparam logic [4:0] S_NUM    = 5'd18;
    localparam logic [4:0] S_IWAIT  = 5'd19;
    localparam logic [4:0] S_FIN    = 5'd20;

    logic [4:0]                  state_reg, state_next;
    logic [ctti_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ctti_pkg::STEP_W-1:0] idx_reg, idx_next;
    logic                        simple_reg, simple_next;
    logic                        done_reg, done_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        simple_next = simple_reg;
        done_next   = 1'b0;
        cmd.op      = ctti_pkg::OP_NONE;
        cmd.taddr   = '0;
        cmd.vstep   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && sts.is_query)
                begin
                    if (sts.row_bad)
                    begin
                        cmd.op    = ctti_pkg::OP_ROWBAD;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        // The first time entry is read on the accepting edge.
                        cmd.op     = ctti_pkg::OP_LATCH;
                        state_next = S_RD1;
                    end
                end
            end
            S_RD1:
            begin
                cmd.op     = ctti_pkg::OP_CAP_T0;
                cmd.taddr  = sts.n_last;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.op = ctti_pkg::OP_CAP_TLAST;
                if (!sts.cycle_en)
                    state_next = S_CMP;
                else if (sts.adaptive)
                    state_next = S_CFIX;
                else
                    state_next = S_CSTART;
            end
            S_CSTART:
            begin
                cmd.op     = ctti_pkg::OP_CDIV;
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (!sts.div_busy)
                    state_next = S_CFIX;
            end
            S_CFIX:
            begin
                cmd.op     = ctti_pkg::OP_CFIX;
                state_next = S_PER;
            end
            S_PER:
            begin
                cmd.op     = ctti_pkg::OP_PER;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (sts.p_pos)
                begin
                    cmd.op     = ctti_pkg::OP_MDIV;
                    state_next = S_MWAIT;
                end
                else
                    state_next = S_CMP;
            end
            S_MWAIT:
            begin
                if (!sts.div_busy)
                    state_next = S_WRAP;
            end
            S_WRAP:
            begin
                cmd.op     = ctti_pkg::OP_WRAP;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.t_lt_t0)
                begin
                    idx_next    = '0;
                    simple_next = 1'b1;
                    state_next  = S_V0;
                end
                else if (sts.t_gt_tlast)
                begin
                    idx_next    = sts.n_last;
                    simple_next = 1'b1;
                    state_next  = S_V0;
                end
                else
                    state_next = S_SR1;
            end
            S_SR1:
            begin
                cmd.op = ctti_pkg::OP_SR_PREV;
                if (sts.n_last == '0)
                    state_next = S_SRL;
                else
                begin
                    cmd.taddr  = 6'd1;
                    cnt_next   = 6'd1;
                    state_next = S_SR2;
                end
            end
            S_SR2:
            begin
                // Previous entry is tested for an exact match before the bracket.
                if (sts.eq_prev)
                begin
                    idx_next    = cnt_reg - 1'b1;
                    simple_next = 1'b1;
                    state_next  = S_V0;
                end
                else if (sts.brkt)
                begin
                    cmd.op      = ctti_pkg::OP_SR_BRKT;
                    idx_next    = cnt_reg - 1'b1;
                    simple_next = !sts.interp_en;
                    state_next  = S_V0;
                end
                else
                begin
                    cmd.op = ctti_pkg::OP_SR_PREV;
                    if (cnt_reg == sts.n_last)
                        state_next = S_SRL;
                    else
                    begin
                        cnt_next  = cnt_reg + 1'b1;
                        cmd.taddr = cnt_reg + 1'b1;
                    end
                end
            end
            S_SRL:
            begin
                if (sts.eq_prev)
                begin
                    idx_next    = sts.n_last;
                    simple_next = 1'b1;
                    state_next  = S_V0;
                end
                else
                begin
                    cmd.op     = ctti_pkg::OP_RES_NOINT;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_V0:
                state_next = S_V1;
            S_V1:
            begin
                if (simple_reg)
                begin
                    cmd.op     = ctti_pkg::OP_RES_VAL;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = ctti_pkg::OP_CAP_V0;
                    cmd.vstep  = idx_reg + 1'b1;
                    state_next = S_V2;
                end
            end
            S_V2:
            begin
                cmd.op     = ctti_pkg::OP_MUL_START;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op = ctti_pkg::OP_MUL_STEP;
                if (cnt_reg == ctti_pkg::MUL_STEPS - 1'b1)
                    state_next = S_NUM;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_NUM:
            begin
                cmd.op     = ctti_pkg::OP_IDIV;
                state_next = S_IWAIT;
            end
            S_IWAIT:
            begin
                if (!sts.div_busy)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op     = ctti_pkg::OP_RES_INTERP;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            simple_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            simple_reg <= simple_next;
            done_reg   <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

### rtl/cyclic_time_table_interpolator.sv
// Top level of the cyclic time-table interpolator.
// Depends on ctti_pkg, ctti_ctrl and ctti_dp.
//
// A request is taken at a rising edge with start high and busy low. Function
// FUNC_TIME writes one time sample, FUNC_VALUE one value entry; both are
// written at that edge, give no result and leave busy low, so loads may be
// issued every cycle. FUNC_QUERY returns one result: done is high for exactly
// one cycle with result valid, and the receiver cannot hold it off.
// A query with a row outside rows_in_use answers on the next cycle. Otherwise
// busy stays high while the controller works: it reads the first and last
// sample; in cycle mode it runs the ceiling division (not in adaptive mode)
// and, for a positive period, the modulo division in the shared divider;
// then, for a time inside the table, a linear search of one sample per cycle;
// one value read, or two, a shift-add multiply and a division to interpolate.
// The next request may be accepted in the cycle in which done is high.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle; the
// user must keep to this, as the block does not enforce it.
// Reset restores the register defaults; the tables are undefined until loaded.
module cyclic_time_table_interpolator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  ctti_pkg::req_t             request,
    output logic                       busy,
    output logic                       done,
    output ctti_pkg::res_t             result,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [ctti_pkg::DT_W-1:0]  cfg_data
);

    ctti_pkg::cmd_t cmd;
    ctti_pkg::sts_t sts;
    logic           busy_i;
    logic           accept;

    assign accept = start && !busy_i;

    ctti_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy_i),
        .done  (done)
    );

    ctti_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .result    (result)
    );

    assign busy = busy_i;

endmodule

### rtl/ctti_checker.sv
// Port-level checker for the cyclic time-table interpolator, bound to the top level.
// Depends on ctti_pkg.
module ctti_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input ctti_pkg::req_t request,
    input logic           busy,
    input logic           done,
    input ctti_pkg::res_t result
);

    // A load request never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.func != ctti_pkg::FUNC_QUERY) |=> !done)
        else $error("result after a load request");

    // An accepted query either starts work or answers at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.func == ctti_pkg::FUNC_QUERY) |=> (busy || done))
        else $error("query request dropped");

    // Finishing a query always delivers its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ctti_pkg::STAT_OK || result.status == ctti_pkg::STAT_NOINT
                  || result.status == ctti_pkg::STAT_ROW))
        else $error("unknown status code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ctti_pkg::STAT_OK) |-> (result.result_value == '0))
        else $error("error result carries a value");

endmodule

bind cyclic_time_table_interpolator ctti_checker u_ctti_checker (.*);

### verif/cyclic_time_table_interpolator_test.sv
// Self-checking testbench for the cyclic time-table interpolator: loads time and
// value tables, issues queries under many register settings and compares each result
// with an internal model of the lookup. Depends on ctti_pkg and the block itself.
`timescale 1ns / 100ps

module cyclic_time_table_interpolator_test;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam longint     TIME_MIN    = -(64'sd1 <<< 47);
    localparam longint     TIME_MAX    = (64'sd1 <<< 47) - 1;
    localparam int         ITEM_GOAL   = 1750;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    ctti_pkg::req_t            request = '0;
    logic                      busy;
    logic                      done;
    ctti_pkg::res_t            result;
    logic                      cfg_we = 1'b0;
    logic [2:0]                cfg_index = '0;
    logic [ctti_pkg::DT_W-1:0] cfg_data = '0;

    // Mirror of the block state, updated as each request is accepted
    longint            time_tab [ctti_pkg::MAX_STEPS];
    int                val_tab  [ctti_pkg::MAX_ROWS][ctti_pkg::MAX_STEPS];
    bit                time_written [ctti_pkg::MAX_STEPS];
    bit                val_written  [ctti_pkg::MAX_ROWS][ctti_pkg::MAX_STEPS];
    int                steps_used;
    int                rows_used;
    bit                interp_on;
    bit                cycle_on;
    bit                adaptive_on;
    longint            step_dt;

    ctti_pkg::res_t    pending_results [$];
    int                mismatch_count = 0;
    int                item_count = 0;
    bit                no_gaps = 1'b0;

    cyclic_time_table_interpolator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Rounded linear interpolation, exact in 128 bits
    function automatic longint interpolate_value(longint v0, longint v1, longint off,
                                                 longint den);
        longint              dv;
        logic [127:0]        mag;
        logic [127:0]        quot;
        dv   = v1 - v0;
        mag  = (dv < 0) ? 128'(-dv) : 128'(dv);
        quot = (mag * 128'(off) * 2 + 128'(den)) / (128'(den) * 2);
        return (dv < 0) ? v0 - longint'(quot) : v0 + longint'(quot);
    endfunction

    function automatic ctti_pkg::res_t predict_table_lookup(ctti_pkg::req_t r);
        ctti_pkg::res_t res;
        longint t;
        longint t0;
        longint t1;
        longint dt;
        longint k;
        longint p;
        longint d;
        longint rm;
        longint value;
        bit     found;
        int     row;
        int     n;
        res   = '0;
        t     = {{16{r.time_in[ctti_pkg::TIME_W-1]}}, r.time_in};
        row   = int'(r.row_index);
        n     = steps_used;
        found = 1'b0;
        value = 0;
        if (row >= rows_used)
        begin
            res.status = ctti_pkg::STAT_ROW;
            return res;
        end
        if (cycle_on)
        begin
            t0 = time_tab[0];
            t1 = time_tab[n-1];
            if (!adaptive_on)
            begin
                dt = (step_dt == 0) ? 1 : step_dt;
                k  = (t1 >= 0) ? (t1 + dt - 1) / dt : -((-t1) / dt);
                t1 = k * dt;
            end
            p = t1 - t0;
            if (p > 0)
            begin
                d  = (t >= t0) ? t - t0 : t0 - t;
                rm = d % p;
                if (t >= t0)
                    t = (rm == 0) ? t1 : t0 + rm;
                else
                    t = t0 + p - rm;
            end
        end
        if (t < time_tab[0])
        begin
            value = val_tab[row][0];
            found = 1'b1;
        end
        else if (t > time_tab[n-1])
        begin
            value = val_tab[row][n-1];
            found = 1'b1;
        end
        else
        begin
            for (int i = 0; i < n && !found; i++)
            begin
                if (t == time_tab[i])
                begin
                    value = val_tab[row][i];
                    found = 1'b1;
                end
                else if (i + 1 < n && time_tab[i] < t && t < time_tab[i+1])
                begin
                    if (interp_on)
                        value = interpolate_value(val_tab[row][i], val_tab[row][i+1],
                                                  t - time_tab[i], time_tab[i+1] - time_tab[i]);
                    else
                        value = val_tab[row][i];
                    found = 1'b1;
                end
            end
        end
        res.status       = found ? ctti_pkg::STAT_OK : ctti_pkg::STAT_NOINT;
        res.result_value = found ? value[ctti_pkg::VAL_W-1:0] : '0;
        return res;
    endfunction

    // Result checker: each strobe is matched with the oldest outstanding query
    always @(posedge clk)
    begin
        ctti_pkg::res_t want;
        if (done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: value %h status %0d",
                             result.result_value, result.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.result_value !== want.result_value || result.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected value %h status %0d, got %h %0d",
                                 want.result_value, want.status,
                                 result.result_value, result.status);
                end
            end
        end
    end

    task automatic send_request(input ctti_pkg::req_t r);
        @(negedge clk);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (r.func)
            ctti_pkg::FUNC_TIME:
            begin
                time_tab[r.step_index]     = {{16{r.time_in[ctti_pkg::TIME_W-1]}}, r.time_in};
                time_written[r.step_index] = 1'b1;
                item_count++;
            end
            ctti_pkg::FUNC_VALUE:
            begin
                val_tab[r.row_index][r.step_index]     = r.value_in;
                val_written[r.row_index][r.step_index] = 1'b1;
                item_count++;
            end
            ctti_pkg::FUNC_QUERY:
            begin
                pending_results.push_back(predict_table_lookup(r));
                item_count++;
            end
            default: ;
        endcase
    endtask

    // Random gap after a request: mostly none or short, now and then long
    task automatic sender_gap();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 55)
            len = 0;
        else if (pick < 92)
            len = $urandom_range(1, 4);
        else
            len = $urandom_range(20, 300);
        if (len > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (len - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[ctti_pkg::DT_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            ctti_pkg::REG_STEPS:
            begin
                steps_used = int'(value & 64'h7f);
                if (steps_used < 1) steps_used = 1;
                if (steps_used > ctti_pkg::MAX_STEPS) steps_used = ctti_pkg::MAX_STEPS;
            end
            ctti_pkg::REG_ROWS:
            begin
                rows_used = int'(value & 64'h1f);
                if (rows_used < 1) rows_used = 1;
                if (rows_used > ctti_pkg::MAX_ROWS) rows_used = ctti_pkg::MAX_ROWS;
            end
            ctti_pkg::REG_INTERP:   interp_on   = value[0];
            ctti_pkg::REG_CYCLE:    cycle_on    = value[0];
            ctti_pkg::REG_ADAPTIVE: adaptive_on = value[0];
            ctti_pkg::REG_DT:       step_dt     = value & ((64'sd1 <<< ctti_pkg::DT_W) - 1);
            default: ;
        endcase
    endtask

    task automatic configure(input longint steps, input longint rows, input bit interp,
                             input bit cyc, input bit adapt, input longint dt);
        wait_idle();
        write_reg(ctti_pkg::REG_STEPS, steps);
        write_reg(ctti_pkg::REG_ROWS, rows);
        write_reg(ctti_pkg::REG_INTERP, interp);
        write_reg(ctti_pkg::REG_CYCLE, cyc);
        write_reg(ctti_pkg::REG_ADAPTIVE, adapt);
        write_reg(ctti_pkg::REG_DT, dt);
    endtask

    task automatic load_time(input int idx, input longint t);
        ctti_pkg::req_t r;
        r            = '0;
        r.func       = ctti_pkg::FUNC_TIME;
        r.step_index = ctti_pkg::STEP_W'(idx);
        r.time_in    = t[ctti_pkg::TIME_W-1:0];
        r.value_in   = $urandom;
        r.row_index  = ctti_pkg::ROW_W'($urandom);
        send_request(r);
        sender_gap();
    endtask

    task automatic load_value(input int row, input int idx, input int v);
        ctti_pkg::req_t r;
        r            = '0;
        r.func       = ctti_pkg::FUNC_VALUE;
        r.step_index = ctti_pkg::STEP_W'(idx);
        r.row_index  = ctti_pkg::ROW_W'(row);
        r.value_in   = v;
        r.time_in    = ctti_pkg::TIME_W'({$urandom, $urandom});
        send_request(r);
        sender_gap();
    endtask

    function automatic int random_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return $urandom_range(0, 8191) - 4096;
            default: return $urandom;
        endcase
    endfunction

    // Strictly ascending times for every step in use; rows 0, 1, 2 and the last row
    // in use get values, so any other row in use is queried only once loaded
    task automatic load_tables(input bit base_min, input bit top_max);
        longint           t;
        longint unsigned  mask;
        int               shift;
        shift = $urandom_range(0, 40);
        mask  = (64'd1 << shift) - 1;
        t     = base_min ? TIME_MIN : (longint'($signed({$urandom, $urandom})) >>> 18);
        for (int i = 0; i < steps_used; i++)
        begin
            if (top_max && i == steps_used - 1 && steps_used > 1)
                t = TIME_MAX;
            load_time(i, t);
            t = t + 1 + longint'({$urandom, $urandom} & mask);
        end
        for (int row = 0; row < rows_used; row++)
            if (row < 3 || row == rows_used - 1)
                for (int i = 0; i < steps_used; i++)
                    load_value(row, i, random_value());
    endtask

    function automatic bit row_loaded(int row);
        for (int i = 0; i < steps_used; i++)
            if (!val_written[row][i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic longint query_time();
        longint           t0;
        longint           tl;
        longint           diff;
        longint unsigned  rnd;
        int               i;
        t0  = time_tab[0];
        tl  = time_tab[steps_used-1];
        rnd = {$urandom, $urandom};
        i   = $urandom_range(0, steps_used - 1);
        case ($urandom_range(0, 9))
            0, 1: return time_tab[i];
            2, 3, 4:
            begin
                if (steps_used < 2) return t0 + 1;
                i    = $urandom_range(0, steps_used - 2);
                diff = time_tab[i+1] - time_tab[i];
                if (diff <= 1) return time_tab[i];
                return time_tab[i] + 1 + longint'(rnd % longint'(diff - 1));
            end
            5:   return t0 - $urandom_range(1, 1000);
            6:   return tl + $urandom_range(1, 1000);
            7:   return t0 + (tl - t0) * (int'($urandom_range(0, 6)) - 3)
                        + int'($urandom_range(0, 4)) - 2;
            8:   return longint'($signed(rnd[ctti_pkg::TIME_W-1:0]));
            default: return t0 + longint'(rnd % 64'd1_000_000_000) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    task automatic run_queries(input int count);
        ctti_pkg::req_t r;
        int     row;
        int     pick;
        longint qt;
        for (int q = 0; q < count; q++)
        begin
            pick = $urandom_range(0, 99);
            r    = '0;
            if (pick < 3)
            begin
                // ignored function code, must give no result
                r.func       = FUNC_UNUSED;
                r.step_index = ctti_pkg::STEP_W'($urandom);
                r.row_index  = ctti_pkg::ROW_W'($urandom);
                r.time_in    = ctti_pkg::TIME_W'({$urandom, $urandom});
                r.value_in   = $urandom;
                send_request(r);
            end
            else if (pick < 13)
            begin
                // rewrite a value that is already part of the table
                row = $urandom_range(0, rows_used - 1);
                if (!row_loaded(row)) row = 0;
                r.func       = ctti_pkg::FUNC_VALUE;
                r.row_index  = ctti_pkg::ROW_W'(row);
                r.step_index = ctti_pkg::STEP_W'($urandom_range(0, steps_used - 1));
                r.value_in   = random_value();
                send_request(r);
            end
            else
            begin
                row = $urandom_range(0, ctti_pkg::MAX_ROWS - 1);
                if (row < rows_used && !row_loaded(row))
                    row = $urandom_range(0, 2) < rows_used ? $urandom_range(0, 2) : 0;
                if (row < rows_used && !row_loaded(row))
                    row = 0;
                qt           = query_time();
                r.func       = ctti_pkg::FUNC_QUERY;
                r.row_index  = ctti_pkg::ROW_W'(row);
                r.step_index = ctti_pkg::STEP_W'($urandom);
                r.value_in   = $urandom;
                r.time_in    = qt[ctti_pkg::TIME_W-1:0];
                send_request(r);
            end
            sender_gap();
        end
    endtask

    task automatic test_defaults();
        ctti_pkg::req_t r;
        // reset values: one sample, one row, interpolation on, no cycling
        load_time(0, 64'sh10000);
        load_value(0, 0, 32'h7fff_ffff);
        r          = '0;
        r.func     = ctti_pkg::FUNC_QUERY;
        r.time_in  = TIME_MIN[ctti_pkg::TIME_W-1:0];
        send_request(r);
        r.time_in  = TIME_MAX[ctti_pkg::TIME_W-1:0];
        send_request(r);
        r.time_in  = 48'h10000;
        send_request(r);
        r.row_index = 4'd15;
        send_request(r);
        r.row_index = 4'd1;
        send_request(r);
        r.func      = FUNC_UNUSED;
        send_request(r);
        load_value(0, 0, 32'h8000_0000);
        r.func      = ctti_pkg::FUNC_QUERY;
        r.row_index = 4'd0;
        r.time_in   = 48'h0;
        send_request(r);
        sender_gap();
    endtask

    task automatic test_interpolation();
        configure(8, 4, 1, 0, 0, 65536);
        load_tables(1'b1, 1'b1);
        // largest value step between neighbours
        load_value(0, 3, 32'h8000_0000);
        load_value(0, 4, 32'h7fff_ffff);
        run_queries(40);
    endtask

    task automatic test_hold();
        configure(6, 3, 0, 0, 0, 65536);
        load_tables(1'b0, 1'b0);
        run_queries(30);
    endtask

    task automatic test_cycle_fixed_step();
        configure(5, 2, 1, 1, 0, $urandom_range(1, 200000));
        load_tables(1'b0, 1'b0);
        run_queries(30);
        configure(4, 2, 1, 1, 0, 1);
        load_tables(1'b0, 1'b0);
        run_queries(20);
        configure(4, 2, 0, 1, 0, (64'sd1 <<< ctti_pkg::DT_W) - 1);
        load_tables(1'b0, 1'b0);
        run_queries(20);
    endtask

    task automatic test_cycle_adaptive();
        configure(7, 3, 1, 1, 1, 65536);
        load_tables(1'b0, 1'b0);
        run_queries(30);
        // a single sample gives an empty period
        configure(1, 1, 1, 1, 1, 65536);
        load_tables(1'b0, 1'b0);
        run_queries(10);
    endtask

    task automatic test_register_limits();
        configure(0, 0, 1, 1, 0, 0);
        load_tables(1'b0, 1'b0);
        run_queries(10);
        configure(127, 31, 1, 0, 0, 65536);
        load_tables(1'b1, 1'b1);
        run_queries(30);
        configure(64, 16, 1, 1, 0, (64'sd1 <<< ctti_pkg::DT_W) - 1);
        run_queries(20);
    endtask

    task automatic test_unordered_table();
        longint held;
        configure(6, 2, 1, 0, 0, 65536);
        load_tables(1'b0, 1'b0);
        // swap two samples so some queries find no bracketing pair
        held = time_tab[1];
        load_time(1, time_tab[4]);
        load_time(4, held);
        run_queries(30);
        wait_idle();
        write_reg(ctti_pkg::REG_CYCLE, 1);
        run_queries(20);
    endtask

    task automatic test_random_settings();
        longint dt;
        while (item_count < ITEM_GOAL)
        begin
            case ($urandom_range(0, 3))
                0:       dt = 1;
                1:       dt = $urandom_range(1, 1 << 20);
                2:       dt = longint'({$urandom, $urandom}) & ((64'sd1 <<< ctti_pkg::DT_W) - 1);
                default: dt = 65536;
            endcase
            configure(($urandom_range(0, 9) == 0) ? 64 : $urandom_range(1, 12),
                      $urandom_range(1, 16), $urandom_range(0, 1), $urandom_range(0, 1),
                      $urandom_range(0, 1), dt);
            no_gaps = ($urandom_range(0, 3) == 0);
            load_tables($urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
            if ($urandom_range(0, 7) == 0 && steps_used > 2)
                load_time(0, time_tab[steps_used-1] + 5);
            run_queries($urandom_range(20, 60));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        steps_used  = 1;
        rows_used   = 1;
        interp_on   = 1'b1;
        cycle_on    = 1'b0;
        adaptive_on = 1'b0;
        step_dt     = 65536;
        foreach (time_tab[i])
        begin
            time_tab[i]     = 0;
            time_written[i] = 1'b0;
        end
        foreach (val_tab[r, i])
        begin
            val_tab[r][i]     = 0;
            val_written[r][i] = 1'b0;
        end
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_interpolation();
        test_hold();
        test_cycle_fixed_step();
        test_cycle_adaptive();
        test_register_limits();
        test_unordered_table();
        test_random_settings();

        wait_idle();
        repeat (300)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
rtl/ctti_pkg.sv
rtl/ctti_div.sv
rtl/ctti_dp.sv
rtl/ctti_ctrl.sv
rtl/cyclic_time_table_interpolator.sv
rtl/ctti_checker.sv
verif/cyclic_time_table_interpolator_test.sv
